@@ rtl/lsnh_pkg.sv @@
// Package for the line sensor normalize/hysteresis block.
// Holds widths, reset values, register indexes, FSM states and the structs
// that pass between the configuration, controller and datapath modules.
`timescale 1ns / 1ps
`default_nettype none

package lsnh_pkg;

  localparam int NUM_CH   = 8;
  localparam int CH_W     = 3;
  localparam int SAMPLE_W = 12;
  localparam int SEQ_W    = 32;
  localparam int STR_W    = 10;
  localparam int CAL_W    = 48;
  localparam int ORDER_W  = 24;
  localparam int LVL_W    = 10;
  localparam int SPAN_W   = 12;
  localparam int IDX_W    = 3;
  localparam int DIFF_W   = SAMPLE_W + 1;
  localparam int PROD_W   = SAMPLE_W + STR_W;
  localparam int QUO_W    = STR_W;
  localparam int DSH_W    = SAMPLE_W + QUO_W - 1;
  localparam int STEP_W   = 4;

  localparam logic [STR_W-1:0]   STR_MAX      = 10'd1000;
  localparam logic [NUM_CH-1:0]  ALL_CH       = 8'hFF;
  localparam logic [ORDER_W-1:0] ORDER_RESET  = 24'hFAC688;
  localparam logic [LVL_W-1:0]   BON_RESET    = 10'd600;
  localparam logic [LVL_W-1:0]   WON_RESET    = 10'd400;
  localparam logic [SPAN_W-1:0]  SPAN_RESET   = 12'd100;
  localparam logic [STEP_W-1:0]  DIV_LAST     = 4'd9;

  typedef enum logic [IDX_W-1:0] {
    REG_WHITE_LO  = 3'd0,
    REG_WHITE_HI  = 3'd1,
    REG_BLACK_LO  = 3'd2,
    REG_BLACK_HI  = 3'd3,
    REG_ORDER     = 3'd4,
    REG_BLACK_ON  = 3'd5,
    REG_WHITE_ON  = 3'd6,
    REG_MIN_SPAN  = 3'd7
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_LOAD,
    ST_DIV,
    ST_NEXT,
    ST_EMIT
  } state_e;

  typedef logic [NUM_CH-1:0][SAMPLE_W-1:0] sample_arr_t;
  typedef logic [NUM_CH-1:0][STR_W-1:0]    str_arr_t;

  typedef struct packed {
    logic [CAL_W-1:0]   white_lo;
    logic [CAL_W-1:0]   white_hi;
    logic [CAL_W-1:0]   black_lo;
    logic [CAL_W-1:0]   black_hi;
    logic [ORDER_W-1:0] order;
    logic [LVL_W-1:0]   black_on;
    logic [LVL_W-1:0]   white_on;
    logic [SPAN_W-1:0]  min_span;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic start;
    logic load;
    logic div_step;
    logic finish;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic skip;
    logic last_ch;
    logic out_free;
  } ctrl_sts_t;

endpackage

`default_nettype wire

@@ rtl/lsnh_cfg.sv @@
// Configuration register file: eight registers written over a valid/ready port.
// Depends on lsnh_pkg; flags writes to calibration registers.
`timescale 1ns / 1ps
`default_nettype none

module lsnh_cfg (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_valid_i,
  input  wire logic [lsnh_pkg::IDX_W-1:0] cfg_index_i,
  input  wire logic [lsnh_pkg::CAL_W-1:0] cfg_data_i,
  output lsnh_pkg::cfg_t                  cfg_o,
  output logic                            cal_wr_o
);
  import lsnh_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d    = cfg_q;
    cal_wr_o = 1'b0;
    if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_WHITE_LO: begin
          cfg_d.white_lo = cfg_data_i;
          cal_wr_o       = 1'b1;
        end
        REG_WHITE_HI: begin
          cfg_d.white_hi = cfg_data_i;
          cal_wr_o       = 1'b1;
        end
        REG_BLACK_LO: begin
          cfg_d.black_lo = cfg_data_i;
          cal_wr_o       = 1'b1;
        end
        REG_BLACK_HI: begin
          cfg_d.black_hi = cfg_data_i;
          cal_wr_o       = 1'b1;
        end
        REG_ORDER:    cfg_d.order    = cfg_data_i[ORDER_W-1:0];
        REG_BLACK_ON: cfg_d.black_on = cfg_data_i[LVL_W-1:0];
        REG_WHITE_ON: cfg_d.white_on = cfg_data_i[LVL_W-1:0];
        REG_MIN_SPAN: cfg_d.min_span = cfg_data_i[SPAN_W-1:0];
        default:      cfg_d          = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.white_lo <= '0;
      cfg_q.white_hi <= '0;
      cfg_q.black_lo <= '0;
      cfg_q.black_hi <= '0;
      cfg_q.order    <= ORDER_RESET;
      cfg_q.black_on <= BON_RESET;
      cfg_q.white_on <= WON_RESET;
      cfg_q.min_span <= SPAN_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ rtl/lsnh_ctrl.sv @@
// Sequencer for one snapshot: check, then per channel load, divide, store, then emit.
// Depends on lsnh_pkg; drives the datapath through ctrl_cmd_t and reads ctrl_sts_t.
`timescale 1ns / 1ps
`default_nettype none

module lsnh_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire lsnh_pkg::ctrl_sts_t sts_i,
  output lsnh_pkg::ctrl_cmd_t      cmd_o
);
  import lsnh_pkg::*;

  state_e            state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_CHECK;
      ST_CHECK: state_d = sts_i.skip ? ST_IDLE : ST_LOAD;
      ST_LOAD:  state_d = ST_DIV;
      ST_DIV:   if (step_q == '0) state_d = ST_NEXT;
      ST_NEXT:  state_d = sts_i.last_ch ? ST_EMIT : ST_LOAD;
      ST_EMIT:  if (sts_i.out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    step_d     = step_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_CHECK: cmd_o.start = !sts_i.skip;
      ST_LOAD: begin
        cmd_o.load = 1'b1;
        step_d     = DIV_LAST;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q - 1'b1;
      end
      ST_NEXT:  cmd_o.finish = 1'b1;
      ST_EMIT:  cmd_o.emit   = sts_i.out_free;
      default:  cmd_o        = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/lsnh_dpath.sv @@
// Datapath: snapshot capture, channel reorder, span check, shared restoring
// divider, hysteresis and the output register. Depends on lsnh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lsnh_dpath (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire lsnh_pkg::cfg_t              cfg_i,
  input  wire logic                        cal_wr_i,
  input  wire lsnh_pkg::ctrl_cmd_t         cmd_i,
  output lsnh_pkg::ctrl_sts_t              sts_o,
  input  wire lsnh_pkg::sample_arr_t       samples_i,
  input  wire logic [lsnh_pkg::SEQ_W-1:0]  seq_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output lsnh_pkg::str_arr_t               strength_o,
  output logic [lsnh_pkg::NUM_CH-1:0]      chan_ok_o,
  output logic [lsnh_pkg::NUM_CH-1:0]      chan_dark_o,
  output logic [lsnh_pkg::SEQ_W-1:0]       frame_seq_o
);
  import lsnh_pkg::*;

  // snapshot and history
  sample_arr_t        samp_q;
  logic [SEQ_W-1:0]   seq_q, last_seq_q;
  logic [NUM_CH-1:0]  prev_black_q;
  logic [CH_W-1:0]    ch_q;

  // per-channel divider state
  logic [PROD_W-1:0]  rem_q;
  logic [DSH_W-1:0]   dsh_q;
  logic [QUO_W-1:0]   quo_q;
  logic               zero_q, sat_q, chval_q;

  // frame being assembled
  str_arr_t           str_acc_q;
  logic [NUM_CH-1:0]  vmask_acc_q, bmask_acc_q;

  // output register
  logic               out_valid_q;
  str_arr_t           out_str_q;
  logic [NUM_CH-1:0]  out_vmask_q, out_bmask_q;
  logic [SEQ_W-1:0]   out_seq_q;

  // permutation check
  logic [NUM_CH-1:0]  seen;
  always_comb begin
    seen = '0;
    for (int i = 0; i < NUM_CH; i++) begin
      seen[cfg_i.order[i*CH_W +: CH_W]] = 1'b1;
    end
  end

  assign sts_o.skip     = (seq_q == last_seq_q) || (seen != ALL_CH);
  assign sts_o.last_ch  = (ch_q == CH_W'(NUM_CH - 1));
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  // channel load: reorder, calibration lookup, signs and scaled numerator
  logic [CH_W-1:0]     phys;
  logic [SAMPLE_W-1:0] raw, white, blk;
  logic [CAL_W-1:0]    white_word, black_word;
  logic [DIFF_W-1:0]   num_s, den_s;
  logic [SAMPLE_W-1:0] num_abs, den_abs;
  logic [PROD_W-1:0]   prod;

  always_comb begin
    phys       = cfg_i.order[ch_q*CH_W +: CH_W];
    raw        = samp_q[phys];
    white_word = ch_q[CH_W-1] ? cfg_i.white_hi : cfg_i.white_lo;
    black_word = ch_q[CH_W-1] ? cfg_i.black_hi : cfg_i.black_lo;
    white      = white_word[ch_q[CH_W-2:0]*SAMPLE_W +: SAMPLE_W];
    blk        = black_word[ch_q[CH_W-2:0]*SAMPLE_W +: SAMPLE_W];
    num_s      = {1'b0, raw} - {1'b0, white};
    den_s      = {1'b0, blk} - {1'b0, white};
    num_abs    = num_s[DIFF_W-1] ? SAMPLE_W'(-num_s) : num_s[SAMPLE_W-1:0];
    den_abs    = den_s[DIFF_W-1] ? SAMPLE_W'(-den_s) : den_s[SAMPLE_W-1:0];
    prod       = PROD_W'(num_abs) * PROD_W'(STR_MAX);
  end

  // one quotient bit per step
  logic                rem_ge;
  assign rem_ge = (rem_q >= PROD_W'(dsh_q));

  // store: select strength, apply hysteresis
  logic [STR_W-1:0]    s_val;
  logic                dark_now;
  always_comb begin
    if (!chval_q || zero_q) begin
      s_val = '0;
    end else if (sat_q) begin
      s_val = STR_MAX;
    end else begin
      s_val = quo_q;
    end
    if (prev_black_q[ch_q]) begin
      dark_now = chval_q && (s_val > cfg_i.white_on);
    end else begin
      dark_now = chval_q && (s_val >= cfg_i.black_on);
    end
  end

  // control and history registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_seq_q   <= '0;
      prev_black_q <= '0;
      ch_q         <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        ch_q <= '0;
      end else if (cmd_i.finish) begin
        ch_q <= ch_q + 1'b1;
      end
      if (cal_wr_i) begin
        prev_black_q <= '0;
      end else if (cmd_i.emit) begin
        prev_black_q <= bmask_acc_q;
      end
      if (cmd_i.emit) begin
        last_seq_q  <= seq_q;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      samp_q <= samples_i;
      seq_q  <= seq_i;
    end
    if (cmd_i.load) begin
      rem_q   <= prod;
      dsh_q   <= {den_abs, (QUO_W-1)'(0)};
      quo_q   <= '0;
      zero_q  <= (num_s == '0) || (den_s == '0) || (num_s[DIFF_W-1] != den_s[DIFF_W-1]);
      sat_q   <= (num_abs >= den_abs);
      chval_q <= (den_abs >= cfg_i.min_span);
    end
    if (cmd_i.div_step) begin
      if (rem_ge) begin
        rem_q <= rem_q - PROD_W'(dsh_q);
      end
      quo_q <= {quo_q[QUO_W-2:0], rem_ge};
      dsh_q <= dsh_q >> 1;
    end
    if (cmd_i.finish) begin
      str_acc_q[ch_q]   <= s_val;
      vmask_acc_q[ch_q] <= chval_q;
      bmask_acc_q[ch_q] <= dark_now;
    end
    if (cmd_i.emit) begin
      out_str_q   <= str_acc_q;
      out_vmask_q <= vmask_acc_q;
      out_bmask_q <= bmask_acc_q;
      out_seq_q   <= seq_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign strength_o  = out_str_q;
  assign chan_ok_o   = out_vmask_q;
  assign chan_dark_o = out_bmask_q;
  assign frame_seq_o = out_seq_q;

endmodule

`default_nettype wire

@@ rtl/line_sensor_normalize_hysteresis_top.sv @@
// Channel      | Handshake               | Payload
// in           | in_valid_i / in_ready_o | sample_0_i..sample_7_i, sample_seq_i
// out          | out_valid_o/ out_ready_i| strength_0_o..7_o, chan_ok_o, chan_dark_o, frame_seq_o
// cfg          | cfg_valid_i/ cfg_ready_o| cfg_index_i, cfg_data_i
//
// A snapshot keeps in_ready_o low after its transfer through the check state, then for
// each of the eight channels a load, ten restoring-divider steps and a store, then the
// emit state that loads the output register. A new snapshot transfers only in idle.
// A repeated sequence or a bad channel order returns to idle from the check state.
// The output register holds a frame while the next snapshot is worked on; a stall
// on out_ready_i only holds the block in its emit state. Reset is asynchronous.
// Depends on lsnh_pkg, lsnh_cfg, lsnh_ctrl and lsnh_dpath.
`timescale 1ns / 1ps
`default_nettype none

module line_sensor_normalize_hysteresis_top (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [lsnh_pkg::SAMPLE_W-1:0] sample_0_i,
  input  wire logic [lsnh_pkg::SAMPLE_W-1:0] sample_1_i,
  input  wire logic [lsnh_pkg::SAMPLE_W-1:0] sample_2_i,
  input  wire logic [lsnh_pkg::SAMPLE_W-1:0] sample_3_i,
  input  wire logic [lsnh_pkg::SAMPLE_W-1:0] sample_4_i,
  input  wire logic [lsnh_pkg::SAMPLE_W-1:0] sample_5_i,
  input  wire logic [lsnh_pkg::SAMPLE_W-1:0] sample_6_i,
  input  wire logic [lsnh_pkg::SAMPLE_W-1:0] sample_7_i,
  input  wire logic [lsnh_pkg::SEQ_W-1:0]    sample_seq_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [lsnh_pkg::STR_W-1:0]       strength_0_o,
  output logic [lsnh_pkg::STR_W-1:0]       strength_1_o,
  output logic [lsnh_pkg::STR_W-1:0]       strength_2_o,
  output logic [lsnh_pkg::STR_W-1:0]       strength_3_o,
  output logic [lsnh_pkg::STR_W-1:0]       strength_4_o,
  output logic [lsnh_pkg::STR_W-1:0]       strength_5_o,
  output logic [lsnh_pkg::STR_W-1:0]       strength_6_o,
  output logic [lsnh_pkg::STR_W-1:0]       strength_7_o,
  output logic [lsnh_pkg::NUM_CH-1:0]      chan_ok_o,
  output logic [lsnh_pkg::NUM_CH-1:0]      chan_dark_o,
  output logic [lsnh_pkg::SEQ_W-1:0]       frame_seq_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [lsnh_pkg::IDX_W-1:0]  cfg_index_i,
  input  wire logic [lsnh_pkg::CAL_W-1:0]  cfg_data_i
);
  import lsnh_pkg::*;

  cfg_t        cfg;
  logic        cal_wr;
  ctrl_cmd_t   cmd;
  ctrl_sts_t   sts;
  sample_arr_t samples;
  str_arr_t    strength;

  assign cfg_ready_o = 1'b1;

  assign samples = {sample_7_i, sample_6_i, sample_5_i, sample_4_i,
                    sample_3_i, sample_2_i, sample_1_i, sample_0_i};

  assign strength_0_o = strength[0];
  assign strength_1_o = strength[1];
  assign strength_2_o = strength[2];
  assign strength_3_o = strength[3];
  assign strength_4_o = strength[4];
  assign strength_5_o = strength[5];
  assign strength_6_o = strength[6];
  assign strength_7_o = strength[7];

  lsnh_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg),
    .cal_wr_o    (cal_wr)
  );

  lsnh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lsnh_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .cal_wr_i     (cal_wr),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .samples_i    (samples),
    .seq_i        (sample_seq_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .strength_o   (strength),
    .chan_ok_o    (chan_ok_o),
    .chan_dark_o  (chan_dark_o),
    .frame_seq_o  (frame_seq_o)
  );

  logic str_over;
  always_comb begin
    str_over = 1'b0;
    for (int i = 0; i < NUM_CH; i++) begin
      if (strength[i] > STR_MAX) str_over = 1'b1;
    end
  end

  // a frame is loaded only into a free output register
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> sts.out_free)
    else $error("frame loaded over an untaken result");

  // an accepted snapshot keeps the input side closed in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted while still checking a snapshot");

  // black channels are always valid channels
  a_black_in_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((chan_dark_o & ~chan_ok_o) == '0))
    else $error("black bit set on an invalid channel");

  // strengths stay within the clamp
  a_strength_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !str_over)
    else $error("strength above full scale");

endmodule

`default_nettype wire

@@ test/line_sensor_normalize_hysteresis_top_tb.sv @@
// Self-checking bench for line_sensor_normalize_hysteresis_top: a directed walk, then
// randomized phases of calibration, channel order and threshold settings with drifting samples.
// Depends on lsnh_pkg and the RTL under rtl/; frames are checked against an in-bench predictor.
`timescale 1ns / 1ps

module line_sensor_normalize_hysteresis_top_tb;
  import lsnh_pkg::*;

  localparam int RANDOM_FRAMES = 2000;
  localparam int SETTLE_CYCLES = 100;
  localparam int STALL_LIMIT   = 2000;
  localparam int FULL_SCALE    = int'(STR_MAX);
  localparam int ADC_TOP       = (1 << SAMPLE_W) - 1;

  typedef struct packed {
    sample_arr_t        adc;
    logic [SEQ_W-1:0]   seq;
  } snapshot_t;

  typedef struct packed {
    str_arr_t           strength;
    logic [NUM_CH-1:0]  chan_ok;
    logic [NUM_CH-1:0]  chan_dark;
    logic [SEQ_W-1:0]   seq;
  } frame_t;

  typedef enum logic [1:0] {
    ROW_WRITE,
    ROW_SNAP,
    ROW_SNAP_NONE,
    ROW_SNAP_EXP
  } row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    reg_idx_e           idx;
    logic [CAL_W-1:0]   data;
    snapshot_t          snap;
    frame_t             want;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic               snap_valid = 1'b0;
  logic               snap_ready;
  snapshot_t          snap_q = '0;
  logic               frame_valid;
  logic               frame_ready = 1'b0;
  wire [NUM_CH-1:0][STR_W-1:0] str_seen;
  logic [NUM_CH-1:0]  vmask_seen;
  logic [NUM_CH-1:0]  bmask_seen;
  logic [SEQ_W-1:0]   seq_seen_o;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [IDX_W-1:0]   cfg_index = '0;
  logic [CAL_W-1:0]   cfg_data = '0;

  // predictor copy of the registers and state
  logic [CAL_W-1:0]   cal_white_lo = '0;
  logic [CAL_W-1:0]   cal_white_hi = '0;
  logic [CAL_W-1:0]   cal_black_lo = '0;
  logic [CAL_W-1:0]   cal_black_hi = '0;
  logic [ORDER_W-1:0] chan_order   = ORDER_RESET;
  logic [LVL_W-1:0]   black_on_lvl = BON_RESET;
  logic [LVL_W-1:0]   white_on_lvl = WON_RESET;
  logic [SPAN_W-1:0]  span_floor   = SPAN_RESET;
  logic [SEQ_W-1:0]   seq_last     = '0;
  logic [NUM_CH-1:0]  black_state  = '0;

  frame_t             frames_due[$];
  dir_row_t           plan[$];
  int unsigned        faults = 0;
  int unsigned        idle_run = 0;
  bit                 cfg_open = 1'b0;
  bit                 source_calm = 1'b0;
  bit                 sink_calm = 1'b0;
  logic [SAMPLE_W-1:0] drift [NUM_CH];
  logic [SEQ_W-1:0]   seq_cursor = '0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  line_sensor_normalize_hysteresis_top uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (snap_valid),
    .in_ready_o   (snap_ready),
    .sample_0_i   (snap_q.adc[0]),
    .sample_1_i   (snap_q.adc[1]),
    .sample_2_i   (snap_q.adc[2]),
    .sample_3_i   (snap_q.adc[3]),
    .sample_4_i   (snap_q.adc[4]),
    .sample_5_i   (snap_q.adc[5]),
    .sample_6_i   (snap_q.adc[6]),
    .sample_7_i   (snap_q.adc[7]),
    .sample_seq_i (snap_q.seq),
    .out_valid_o  (frame_valid),
    .out_ready_i  (frame_ready),
    .strength_0_o (str_seen[0]),
    .strength_1_o (str_seen[1]),
    .strength_2_o (str_seen[2]),
    .strength_3_o (str_seen[3]),
    .strength_4_o (str_seen[4]),
    .strength_5_o (str_seen[5]),
    .strength_6_o (str_seen[6]),
    .strength_7_o (str_seen[7]),
    .chan_ok_o    (vmask_seen),
    .chan_dark_o  (bmask_seen),
    .frame_seq_o  (seq_seen_o),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  function automatic bit order_is_perm(input logic [ORDER_W-1:0] ord);
    logic [NUM_CH-1:0] hit;
    hit = '0;
    for (int k = 0; k < NUM_CH; k++) hit[ord[CH_W*k +: CH_W]] = 1'b1;
    return hit == ALL_CH;
  endfunction

  // Work out the frame a snapshot yields and advance the hysteresis state.
  function automatic bit forecast_frame(input snapshot_t s, output frame_t f);
    logic [SAMPLE_W-1:0] raw, wht, blk;
    int span, den, q;
    bit dark;
    f = '0;
    if (s.seq == seq_last || !order_is_perm(chan_order)) return 1'b0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      raw = s.adc[chan_order[CH_W*ch +: CH_W]];
      wht = (ch < 4) ? cal_white_lo[SAMPLE_W*(ch%4) +: SAMPLE_W]
                     : cal_white_hi[SAMPLE_W*(ch%4) +: SAMPLE_W];
      blk = (ch < 4) ? cal_black_lo[SAMPLE_W*(ch%4) +: SAMPLE_W]
                     : cal_black_hi[SAMPLE_W*(ch%4) +: SAMPLE_W];
      den = int'(blk) - int'(wht);
      span = (den < 0) ? -den : den;
      if (span < int'(span_floor)) continue;
      f.chan_ok[ch] = 1'b1;
      if (den == 0) begin
        q = 0;
      end else begin
        // signed division truncates toward zero, then clamp
        q = ((int'(raw) - int'(wht)) * FULL_SCALE) / den;
        if (q < 0) q = 0;
        else if (q > FULL_SCALE) q = FULL_SCALE;
      end
      f.strength[ch] = q[STR_W-1:0];
      dark = black_state[ch];
      if (dark) begin
        if (q <= int'(white_on_lvl)) dark = 1'b0;
      end else if (q >= int'(black_on_lvl)) begin
        dark = 1'b1;
      end
      f.chan_dark[ch] = dark;
    end
    f.seq = s.seq;
    black_state = f.chan_dark;
    seq_last = s.seq;
    return 1'b1;
  endfunction

  function automatic logic [CAL_W-1:0] noise48();
    return CAL_W'({$urandom, $urandom});
  endfunction

  function automatic frame_t uniform_frame(input logic [STR_W-1:0] lvl,
                                           input logic [NUM_CH-1:0] vm,
                                           input logic [NUM_CH-1:0] bm,
                                           input logic [SEQ_W-1:0] seq);
    frame_t f;
    f.strength = {NUM_CH{lvl}};
    f.chan_ok = vm;
    f.chan_dark = bm;
    f.seq = seq;
    return f;
  endfunction

  function automatic void add_write(input reg_idx_e idx, input logic [CAL_W-1:0] data);
    dir_row_t r;
    r = '0;
    r.kind = ROW_WRITE;
    r.idx = idx;
    r.data = data;
    plan.push_back(r);
  endfunction

  function automatic void add_snap(input row_kind_e kind, input sample_arr_t adc,
                                   input logic [SEQ_W-1:0] seq, input frame_t want);
    dir_row_t r;
    r = '0;
    r.kind = kind;
    r.snap.adc = adc;
    r.snap.seq = seq;
    r.want = want;
    plan.push_back(r);
  endfunction

  // Random-walk each physical channel so the hysteresis sees slow crossings.
  function automatic snapshot_t next_snapshot();
    snapshot_t s;
    int lvl;
    int unsigned pick;
    for (int k = 0; k < NUM_CH; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        drift[k] = SAMPLE_W'($urandom);
      end else if (pick < 8) begin
        drift[k] = pick[0] ? '1 : '0;
      end else begin
        lvl = int'(drift[k]) + int'($urandom_range(0, 600)) - 300;
        drift[k] = (lvl < 0) ? '0 : (lvl > ADC_TOP) ? '1 : SAMPLE_W'(lvl);
      end
      s.adc[k] = drift[k];
    end
    // below 8: keep the sequence, a repeat
    pick = $urandom_range(0, 99);
    if (pick >= 11) seq_cursor = seq_cursor + 1'b1;
    else if (pick >= 8) seq_cursor = $urandom;
    s.seq = seq_cursor;
    return s;
  endfunction

  // Hold the sender until every frame is back, then let the block settle.
  task automatic quiesce(input int settle);
    snap_valid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic program_reg(input reg_idx_e idx, input logic [CAL_W-1:0] data);
    if (!cfg_open) begin
      quiesce(SETTLE_CYCLES);
      cfg_open = 1'b1;
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    case (idx)
      REG_WHITE_LO: begin cal_white_lo = data; black_state = '0; end
      REG_WHITE_HI: begin cal_white_hi = data; black_state = '0; end
      REG_BLACK_LO: begin cal_black_lo = data; black_state = '0; end
      REG_BLACK_HI: begin cal_black_hi = data; black_state = '0; end
      REG_ORDER:    chan_order   = data[ORDER_W-1:0];
      REG_BLACK_ON: black_on_lvl = data[LVL_W-1:0];
      REG_WHITE_ON: white_on_lvl = data[LVL_W-1:0];
      REG_MIN_SPAN: span_floor   = data[SPAN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic send_snapshot(input snapshot_t s, input row_kind_e how, input frame_t want,
                               output bit framed);
    int unsigned gap;
    frame_t due;
    if (cfg_open) begin
      cfg_valid <= 1'b0;
      cfg_open = 1'b0;
    end
    gap = source_calm ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      snap_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    snap_valid <= 1'b1;
    snap_q <= s;
    do @(posedge clk_i); while (!snap_ready);
    framed = forecast_frame(s, due);
    if (how == ROW_SNAP_EXP) frames_due.push_back(want);
    else if (how == ROW_SNAP && framed) frames_due.push_back(due);
  endtask

  task automatic shape_phase();
    logic [CAL_W-1:0] wlo, whi, blo, bhi, data;
    logic [SAMPLE_W-1:0] w, b;
    logic [ORDER_W-1:0] ord;
    int unsigned pick, style, j, tmp;
    int unsigned slot [NUM_CH];
    style = $urandom_range(0, 9);
    for (int ch = 0; ch < NUM_CH; ch++) begin
      if (style < 5) begin
        w = SAMPLE_W'($urandom_range(0, 1200));
        b = SAMPLE_W'($urandom_range(2800, ADC_TOP));
      end else if (style < 7) begin
        w = SAMPLE_W'($urandom_range(2800, ADC_TOP));
        b = SAMPLE_W'($urandom_range(0, 1200));
      end else if (style < 8) begin
        w = SAMPLE_W'($urandom);
        b = SAMPLE_W'($urandom);
      end else if (style < 9) begin
        w = $urandom_range(0, 1) ? '1 : '0;
        b = $urandom_range(0, 1) ? '1 : '0;
      end else begin
        // spans near the usual minimum
        w = SAMPLE_W'($urandom);
        b = w + SAMPLE_W'($urandom_range(0, 300)) - SAMPLE_W'(150);
      end
      if ($urandom_range(0, 9) == 0) b = w;
      if (ch < 4) begin
        wlo[SAMPLE_W*ch +: SAMPLE_W] = w;
        blo[SAMPLE_W*ch +: SAMPLE_W] = b;
      end else begin
        whi[SAMPLE_W*(ch%4) +: SAMPLE_W] = w;
        bhi[SAMPLE_W*(ch%4) +: SAMPLE_W] = b;
      end
    end
    if ($urandom_range(0, 9) < 7) begin
      program_reg(REG_WHITE_LO, wlo);
      program_reg(REG_WHITE_HI, whi);
      program_reg(REG_BLACK_LO, blo);
      program_reg(REG_BLACK_HI, bhi);
    end

    pick = $urandom_range(0, 99);
    if (pick < 85) begin
      for (int k = 0; k < NUM_CH; k++) slot[k] = k;
      for (int k = NUM_CH - 1; k > 0; k--) begin
        j = $urandom_range(0, k);
        tmp = slot[k];
        slot[k] = slot[j];
        slot[j] = tmp;
      end
      for (int k = 0; k < NUM_CH; k++) ord[CH_W*k +: CH_W] = CH_W'(slot[k]);
    end else if (pick < 92) begin
      ord = ORDER_RESET;
    end else begin
      ord = ORDER_W'($urandom);
    end
    data = noise48();
    data[ORDER_W-1:0] = ord;
    program_reg(REG_ORDER, data);

    if ($urandom_range(0, 9) < 6) begin
      data = noise48();
      pick = $urandom_range(0, 9);
      if (pick < 8) data[LVL_W-1:0] = LVL_W'($urandom_range(450, 900));
      else if (pick < 9) data[LVL_W-1:0] = LVL_W'($urandom);
      else data[LVL_W-1:0] = $urandom_range(0, 1) ? STR_MAX : '0;
      program_reg(REG_BLACK_ON, data);
    end
    if ($urandom_range(0, 9) < 6) begin
      data = noise48();
      pick = $urandom_range(0, 9);
      if (pick < 8) data[LVL_W-1:0] = LVL_W'($urandom_range(100, 550));
      else if (pick < 9) data[LVL_W-1:0] = LVL_W'($urandom);
      else data[LVL_W-1:0] = $urandom_range(0, 1) ? STR_MAX : '0;
      program_reg(REG_WHITE_ON, data);
    end
    if ($urandom_range(0, 9) < 6) begin
      data = noise48();
      pick = $urandom_range(0, 9);
      if (pick < 7) data[SPAN_W-1:0] = SPAN_W'($urandom_range(0, 300));
      else if (pick < 8) data[SPAN_W-1:0] = '0;
      else if (pick < 9) data[SPAN_W-1:0] = '1;
      program_reg(REG_MIN_SPAN, data);
    end
  endtask

  // stall limit: count cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (snap_valid && snap_ready) || (frame_valid && frame_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_run <= 0;
    end else begin
      idle_run <= idle_run + 1;
    end
    if (idle_run >= STALL_LIMIT) begin
      $display("line_sensor_normalize_hysteresis_top verification failed");
      $finish;
    end
  end

  initial begin : frame_sink
    int unsigned stall;
    frame_t got;
    frame_t due;
    @(posedge rst_ni);
    forever begin
      stall = sink_calm ? 0 : $urandom_range(0, 17);
      if (stall != 0) begin
        frame_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      frame_ready <= 1'b1;
      do @(posedge clk_i); while (!frame_valid);
      got.strength = str_seen;
      got.chan_ok = vmask_seen;
      got.chan_dark = bmask_seen;
      got.seq = seq_seen_o;
      if (frames_due.size() == 0) begin
        $error("frame_seq %0d arrived with no frame pending", got.seq);
        faults++;
      end else begin
        due = frames_due.pop_front();
        for (int k = 0; k < NUM_CH; k++) begin
          if (got.strength[k] !== due.strength[k]) begin
            $error("strength_%0d: expected %0d, actual %0d", k, due.strength[k],
                   got.strength[k]);
            faults++;
          end
        end
        if (got.chan_ok !== due.chan_ok) begin
          $error("chan_ok: expected %h, actual %h", due.chan_ok, got.chan_ok);
          faults++;
        end
        if (got.chan_dark !== due.chan_dark) begin
          $error("chan_dark: expected %h, actual %h", due.chan_dark, got.chan_dark);
          faults++;
        end
        if (got.seq !== due.seq) begin
          $error("frame_seq: expected %0d, actual %0d", due.seq, got.seq);
          faults++;
        end
      end
    end
  end

  initial begin : stimulus
    bit framed;
    int unsigned produced;
    int unsigned batch;
    snapshot_t s;

    // repeat of the reset sequence, then all channels invalid under reset calibration
    add_snap(ROW_SNAP_NONE, '0, 32'd0, '0);
    add_snap(ROW_SNAP_EXP, '1, 32'd1, uniform_frame('0, '0, '0, 32'd1));
    add_write(REG_WHITE_LO, '0);
    add_write(REG_WHITE_HI, '0);
    add_write(REG_BLACK_LO, '1);
    add_write(REG_BLACK_HI, '1);
    add_snap(ROW_SNAP_EXP, '0, 32'd2, uniform_frame('0, ALL_CH, '0, 32'd2));
    add_snap(ROW_SNAP_EXP, '1, 32'd3, uniform_frame(STR_MAX, ALL_CH, ALL_CH, 32'd3));
    add_snap(ROW_SNAP_NONE, '0, 32'd3, '0);
    // mid level holds black, then the exact turn-white and turn-black levels
    add_snap(ROW_SNAP, {NUM_CH{12'd2048}}, 32'd4, '0);
    add_snap(ROW_SNAP, {NUM_CH{12'd1638}}, 32'd5, '0);
    add_snap(ROW_SNAP, {NUM_CH{12'd2457}}, 32'd6, '0);
    add_snap(ROW_SNAP, {12'd4095, 12'd3000, 12'd2500, 12'd2048,
                        12'd1500, 12'd800, 12'd100, 12'd0}, 32'hFFFF_FFFF, '0);
    // broken channel orders: duplicate physical indexes
    add_write(REG_ORDER, '0);
    add_snap(ROW_SNAP_NONE, {NUM_CH{12'd777}}, 32'd7, '0);
    add_write(REG_ORDER, '1);
    add_snap(ROW_SNAP_NONE, {NUM_CH{12'd777}}, 32'd7, '0);
    // reversed order
    add_write(REG_ORDER, 48'h053977);
    add_snap(ROW_SNAP, {12'd4095, 12'd3510, 12'd2925, 12'd2340,
                        12'd1755, 12'd1170, 12'd585, 12'd0}, 32'd8, '0);
    // inverted calibration, clears the black state
    add_write(REG_WHITE_LO, '1);
    add_write(REG_WHITE_HI, '1);
    add_write(REG_BLACK_LO, '0);
    add_write(REG_BLACK_HI, '0);
    add_snap(ROW_SNAP_EXP, '0, 32'd9, uniform_frame(STR_MAX, ALL_CH, ALL_CH, 32'd9));
    add_snap(ROW_SNAP_EXP, '1, 32'd10, uniform_frame('0, ALL_CH, '0, 32'd10));
    // zero span accepted with no minimum; thresholds at zero toggle the mask
    add_write(REG_MIN_SPAN, '0);
    add_write(REG_WHITE_LO, 48'h800_800_800_800);
    add_write(REG_BLACK_LO, 48'h800_800_800_800);
    add_write(REG_WHITE_HI, 48'h000_FFF_7FF_100);
    add_write(REG_BLACK_HI, 48'hFFF_000_800_164);
    add_write(REG_BLACK_ON, '0);
    add_write(REG_WHITE_ON, '0);
    add_snap(ROW_SNAP, {12'd4095, 12'd0, 12'd2048, 12'd300,
                        12'd1, 12'd2048, 12'd4000, 12'd2049}, 32'd11, '0);
    add_snap(ROW_SNAP, {12'd0, 12'd4095, 12'd2047, 12'd200,
                        12'd2048, 12'd2050, 12'd10, 12'd2000}, 32'd12, '0);
    // top thresholds and the largest span floor
    add_write(REG_BLACK_ON, '1);
    add_write(REG_WHITE_ON, {38'h0, STR_MAX});
    add_write(REG_MIN_SPAN, '1);
    add_write(REG_WHITE_LO, '0);
    add_write(REG_BLACK_LO, '1);
    add_snap(ROW_SNAP, {12'd4095, 12'd4095, 12'd0, 12'd100,
                        12'd3000, 12'd4095, 12'd1000, 12'd2000}, 32'd13, '0);
    add_write(REG_ORDER, {24'h0, ORDER_RESET});
    add_write(REG_BLACK_ON, {38'h0, BON_RESET});
    add_write(REG_WHITE_ON, {38'h0, WON_RESET});
    add_write(REG_MIN_SPAN, {36'h0, SPAN_RESET});

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[r]) begin
      if (plan[r].kind == ROW_WRITE) program_reg(plan[r].idx, plan[r].data);
      else send_snapshot(plan[r].snap, plan[r].kind, plan[r].want, framed);
    end

    for (int k = 0; k < NUM_CH; k++) drift[k] = SAMPLE_W'($urandom);
    seq_cursor = 32'd1000;
    produced = 0;
    while (produced < RANDOM_FRAMES) begin
      shape_phase();
      source_calm = ($urandom_range(0, 4) == 0);
      sink_calm = ($urandom_range(0, 4) == 0);
      batch = order_is_perm(chan_order) ? $urandom_range(30, 150) : 6;
      repeat (batch) begin
        // occasionally drain the pipe completely before the next transfer
        if ($urandom_range(0, 49) == 0) quiesce(0);
        s = next_snapshot();
        send_snapshot(s, ROW_SNAP, '0, framed);
        if (framed) produced++;
      end
    end

    if (cfg_open) begin
      cfg_valid <= 1'b0;
      cfg_open = 1'b0;
    end
    quiesce(SETTLE_CYCLES);
    if (faults == 0) begin
      $display("line_sensor_normalize_hysteresis_top verification clean");
    end else begin
      $display("line_sensor_normalize_hysteresis_top verification failed");
    end
    $finish;
  end

endmodule

@@ line_sensor_normalize_hysteresis_top.f @@
rtl/lsnh_pkg.sv
rtl/lsnh_cfg.sv
rtl/lsnh_ctrl.sv
rtl/lsnh_dpath.sv
rtl/line_sensor_normalize_hysteresis_top.sv
test/line_sensor_normalize_hysteresis_top_tb.sv
